// ===== design/cfbm_pkg.sv =====
// Shared types and constants for the fixed-bank cartridge mapper.
`default_nettype none

package cfbm_pkg;

    localparam int PROGRAM_DEPTH  = 32768;
    localparam int PATTERN_DEPTH  = 8192;
    localparam int WORK_RAM_DEPTH = 8192;
    localparam int TABLE_DEPTH    = 1024;

    localparam int PRG_AW  = $clog2(PROGRAM_DEPTH);
    localparam int PAT_AW  = $clog2(PATTERN_DEPTH);
    localparam int WRAM_AW = $clog2(WORK_RAM_DEPTH);
    localparam int TBL_AW  = $clog2(TABLE_DEPTH);
    localparam int NT_AW   = TBL_AW + 1;

    // Bus action codes.
    localparam logic [2:0] ACT_CPU_RD = 3'd0;
    localparam logic [2:0] ACT_CPU_WR = 3'd1;
    localparam logic [2:0] ACT_PPU_RD = 3'd2;
    localparam logic [2:0] ACT_PPU_WR = 3'd3;
    localparam logic [2:0] ACT_LOAD   = 3'd4;

    // Configuration register indexes.
    localparam logic [7:0] CFG_PRG_BANKS   = 8'd0;
    localparam logic [7:0] CFG_PATTERN     = 8'd1;
    localparam logic [7:0] CFG_WORK_RAM    = 8'd2;
    localparam logic [7:0] CFG_MIRROR_MODE = 8'd3;

    // Mirroring modes.
    localparam logic [1:0] MIRROR_HORIZ = 2'd0;
    localparam logic [1:0] MIRROR_VERT  = 2'd1;

    // Which memory supplies the read data of an access.
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_PRG,
        SRC_PAT,
        SRC_NT,
        SRC_WRAM
    } t_src;

endpackage

`default_nettype wire

// ===== design/cartridge_fixed_bank_mapper_top.sv =====
// Fixed-bank cartridge mapper: decode, four synchronous memories and output register.
// Results: an access is registered in the memory read stage, then in the output register.
// Throughput: one access per cycle unless a clearing pass runs or the result channel stalls.
// Reset: synchronous; configuration returns to defaults, then a clearing pass over every work RAM
// address zeroes work RAM and nametables, during which no access is taken.
// Program ROM and pattern memory keep their contents across reset.
`default_nettype none

module cartridge_fixed_bank_mapper_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Access channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_write_data,
    // Result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_handled,
    output logic [7:0]       o_read_data,
    // Configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    // Configuration registers
    logic [1:0] r_prg_banks;
    logic       r_pattern_present;
    logic       r_work_ram_present;
    logic [1:0] r_mirror_mode;

    // Clearing pass
    logic                       r_clr_busy;
    logic [cfbm_pkg::WRAM_AW-1:0] r_clr_addr;

    // Memories
    logic [7:0] prg_mem  [cfbm_pkg::PROGRAM_DEPTH];
    logic [7:0] pat_mem  [cfbm_pkg::PATTERN_DEPTH];
    logic [7:0] nt_mem   [2*cfbm_pkg::TABLE_DEPTH];
    logic [7:0] wram_mem [cfbm_pkg::WORK_RAM_DEPTH];

    logic [7:0] r_prg_rd;
    logic [7:0] r_pat_rd;
    logic [7:0] r_nt_rd;
    logic [7:0] r_wram_rd;

    // Pipeline
    logic           r_s1_valid;
    logic           r_s1_handled;
    cfbm_pkg::t_src r_s1_src;
    logic           r_out_valid;
    logic           r_out_handled;
    logic [7:0]     r_out_data;

    logic in_xfer;
    logic s1_adv;
    logic [7:0] s1_data;

    // Decode
    logic           dec_handled;
    cfbm_pkg::t_src dec_src;
    logic           dec_we_prg;
    logic           dec_we_pat;
    logic           dec_we_nt;
    logic           dec_we_wram;
    logic [14:0]    prg_off;
    logic [cfbm_pkg::PRG_AW-1:0]  prg_ridx;
    logic [cfbm_pkg::PRG_AW-1:0]  prg_widx;
    logic [cfbm_pkg::PAT_AW-1:0]  pat_idx;
    logic [cfbm_pkg::WRAM_AW-1:0] wram_idx;
    logic [cfbm_pkg::NT_AW-1:0]   nt_idx;
    logic [13:0]    ppu_addr;
    logic           nt_sel;
    logic           nt_mapped;

    // Memory port muxes
    logic                         wram_we;
    logic [cfbm_pkg::WRAM_AW-1:0] wram_widx;
    logic [7:0]                   wram_wdata;
    logic                         nt_we;
    logic [cfbm_pkg::NT_AW-1:0]   nt_widx;
    logic [7:0]                   nt_wdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_banks        <= 2'd2;
            r_pattern_present  <= 1'b1;
            r_work_ram_present <= 1'b0;
            r_mirror_mode      <= cfbm_pkg::MIRROR_HORIZ;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == cfbm_pkg::CFG_PRG_BANKS) begin
                r_prg_banks <= i_cfg_data[1:0];
            end
            if (i_cfg_index == cfbm_pkg::CFG_PATTERN) begin
                r_pattern_present <= i_cfg_data[0];
            end
            if (i_cfg_index == cfbm_pkg::CFG_WORK_RAM) begin
                r_work_ram_present <= i_cfg_data[0];
            end
            if (i_cfg_index == cfbm_pkg::CFG_MIRROR_MODE) begin
                r_mirror_mode <= i_cfg_data[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + cfbm_pkg::WRAM_AW'(1);
            if (r_clr_addr == cfbm_pkg::WRAM_AW'(cfbm_pkg::WORK_RAM_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Handshake: stage 1 moves on whenever the output register is free or drains.
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        ppu_addr = i_address[13:0];
        prg_off  = (r_prg_banks == 2'd1) ? {1'b0, i_address[13:0]} : i_address[14:0];
        prg_ridx = prg_off[cfbm_pkg::PRG_AW-1:0];
        prg_widx = i_address[cfbm_pkg::PRG_AW-1:0];
        pat_idx  = ppu_addr[cfbm_pkg::PAT_AW-1:0];
        wram_idx = i_address[cfbm_pkg::WRAM_AW-1:0];

        nt_sel    = 1'b0;
        nt_mapped = 1'b0;
        if (r_mirror_mode == cfbm_pkg::MIRROR_VERT) begin
            nt_sel    = ppu_addr[10];
            nt_mapped = 1'b1;
        end else if (r_mirror_mode == cfbm_pkg::MIRROR_HORIZ) begin
            nt_sel    = ppu_addr[11];
            nt_mapped = 1'b1;
        end
        nt_idx = {nt_sel, ppu_addr[cfbm_pkg::TBL_AW-1:0]};

        dec_handled = 1'b0;
        dec_src     = cfbm_pkg::SRC_NONE;
        dec_we_prg  = 1'b0;
        dec_we_pat  = 1'b0;
        dec_we_nt   = 1'b0;
        dec_we_wram = 1'b0;

        priority if (i_action == cfbm_pkg::ACT_CPU_RD || i_action == cfbm_pkg::ACT_CPU_WR) begin
            if (i_address[15:13] == 3'b011) begin
                dec_handled = 1'b1;
                if (r_work_ram_present) begin
                    if (i_action == cfbm_pkg::ACT_CPU_RD) begin
                        dec_src = cfbm_pkg::SRC_WRAM;
                    end else begin
                        dec_we_wram = 1'b1;
                    end
                end
            end else if (i_action == cfbm_pkg::ACT_CPU_RD && i_address[15]) begin
                dec_handled = 1'b1;
                dec_src     = cfbm_pkg::SRC_PRG;
            end
        end else if (i_action == cfbm_pkg::ACT_PPU_RD || i_action == cfbm_pkg::ACT_PPU_WR) begin
            if (!ppu_addr[13]) begin
                if (r_pattern_present) begin
                    dec_handled = 1'b1;
                    if (i_action == cfbm_pkg::ACT_PPU_RD) begin
                        dec_src = cfbm_pkg::SRC_PAT;
                    end else begin
                        dec_we_pat = 1'b1;
                    end
                end
            end else if (ppu_addr[13:8] != 6'h3F) begin
                // Nametables are claimed even when no mirroring mode maps them.
                dec_handled = 1'b1;
                if (nt_mapped) begin
                    if (i_action == cfbm_pkg::ACT_PPU_RD) begin
                        dec_src = cfbm_pkg::SRC_NT;
                    end else begin
                        dec_we_nt = 1'b1;
                    end
                end
            end
        end else if (i_action == cfbm_pkg::ACT_LOAD) begin
            dec_handled = 1'b1;
            dec_we_prg  = 1'b1;
        end else begin
            dec_handled = 1'b0;
        end
    end

    // The clearing pass owns the write ports of work RAM and nametables until it ends.
    always_comb begin
        if (r_clr_busy) begin
            wram_we    = 1'b1;
            wram_widx  = r_clr_addr;
            wram_wdata = 8'd0;
            nt_we      = 1'b1;
            nt_widx    = r_clr_addr[cfbm_pkg::NT_AW-1:0];
            nt_wdata   = 8'd0;
        end else begin
            wram_we    = in_xfer && dec_we_wram;
            wram_widx  = wram_idx;
            wram_wdata = i_write_data;
            nt_we      = in_xfer && dec_we_nt;
            nt_widx    = nt_idx;
            nt_wdata   = i_write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && dec_we_prg) begin
            prg_mem[prg_widx] <= i_write_data;
        end
        if (in_xfer) begin
            r_prg_rd <= prg_mem[prg_ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && dec_we_pat) begin
            pat_mem[pat_idx] <= i_write_data;
        end
        if (in_xfer) begin
            r_pat_rd <= pat_mem[pat_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (nt_we) begin
            nt_mem[nt_widx] <= nt_wdata;
        end
        if (in_xfer) begin
            r_nt_rd <= nt_mem[nt_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wram_we) begin
            wram_mem[wram_widx] <= wram_wdata;
        end
        if (in_xfer) begin
            r_wram_rd <= wram_mem[wram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_handled <= dec_handled;
            r_s1_src     <= dec_src;
        end
    end

    always_comb begin
        unique case (r_s1_src)
            cfbm_pkg::SRC_PRG:  s1_data = r_prg_rd;
            cfbm_pkg::SRC_PAT:  s1_data = r_pat_rd;
            cfbm_pkg::SRC_NT:   s1_data = r_nt_rd;
            cfbm_pkg::SRC_WRAM: s1_data = r_wram_rd;
            default:            s1_data = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_handled <= r_s1_handled;
            r_out_data    <= s1_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_handled   = r_out_handled;
    assign o_read_data = r_out_data;

`ifndef SYNTHESIS
    a_no_access_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_in_ready)
        else $error("access taken during clearing pass");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_busy && r_clr_addr == cfbm_pkg::WRAM_AW'(cfbm_pkg::WORK_RAM_DEPTH - 1))
        |=> !r_clr_busy)
        else $error("clearing pass did not end");

    a_unhandled_no_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_handled) |-> (r_s1_src == cfbm_pkg::SRC_NONE))
        else $error("unhandled access selects a memory");

    a_xfer_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_s1_valid)
        else $error("transfer lost before stage one");

    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv) |=> r_out_valid)
        else $error("stage one result dropped");
`endif

endmodule

`default_nettype wire
